// File: sv/pll_pkg.sv
// package for the positional linked list block
// holds command kinds, status codes and field widths; no dependencies
package pll_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned STAT_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        K_INS_FRONT = 3'd0,
        K_INS_BACK  = 3'd1,
        K_INS_POS   = 3'd2,
        K_DEL_FRONT = 3'd3,
        K_DEL_BACK  = 3'd4,
        K_DEL_POS   = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_UNDER  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

endpackage

// File: sv/pll_if.sv
// valid/ready channel interfaces for the positional linked list
// depends on pll_pkg for field widths
interface pll_cmd_if (input logic i_clk);
    logic                           valid;
    logic                           ready;
    logic [pll_pkg::KIND_W-1:0]     kind;
    logic signed [pll_pkg::VALUE_W-1:0] value;
    logic [pll_pkg::POS_W-1:0]      position;
    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

interface pll_rsp_if (input logic i_clk);
    logic                           valid;
    logic                           ready;
    logic signed [pll_pkg::VALUE_W-1:0] data;
    logic [pll_pkg::STAT_W-1:0]     status;
    modport source (output valid, data, status, input ready);
    modport sink   (input valid, data, status, output ready);
endinterface

// File: sv/pll_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module pll_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/positional_linked_list.sv
// Positional linked list: a bounded singly linked list of signed 32-bit words
// held in a pool of CAPACITY nodes with a free chain. Each command transaction
// inserts or deletes at the front, the back or a 1-based position and yields
// one response transaction with the value and a status. A sequencer walks the
// chain one node per link ram read. A rejected command needs no walk, a front
// command no walk either, and a command at the back or a far position walks
// up to the whole list; the walk length sets how long a command takes.
// After reset a clearing pass writes each link ram entry once, chaining the
// link ram into the free list; no command is taken meanwhile. The block takes
// one command at a time; the response sits in an output register until
// taken, and a finished command stalls in its response state while an
// earlier response is still waiting.
// depends on pll_pkg, pll_if and pll_ram
module positional_linked_list #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pll_cmd_if.sink     i_cmd,
    pll_rsp_if.source   o_rsp
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY + 1);   // index incl. null
    // position and hop counter width, wide enough for any position field value
    localparam int unsigned TW = ((LW > pll_pkg::POS_W) ? LW : pll_pkg::POS_W) + 1;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECIDE, S_WALK_RD, S_WALK_HOP, S_WALK_WAIT,
        S_FREE_RD, S_FREE_WAIT, S_LINK, S_DEL_RD, S_DEL_WAIT, S_DEL_FIN, S_RESP
    } t_state;

    t_state r_state;

    // command registers
    logic [pll_pkg::KIND_W-1:0]         r_kind;
    logic signed [pll_pkg::VALUE_W-1:0] r_value;
    logic [TW-1:0]                      r_target;   // 1-based position to act on
    logic [TW-1:0]                      r_step;     // hop counter
    logic [LW-1:0]                      r_prev;     // node before target, NIL for head
    logic [LW-1:0]                      r_node;
    logic [LW-1:0]                      r_head;
    logic [LW-1:0]                      r_free;
    logic [LW-1:0]                      r_count;
    logic [AW-1:0]                      r_init;
    logic signed [pll_pkg::VALUE_W-1:0] r_data;
    logic [pll_pkg::STAT_W-1:0]         r_status;
    logic                               r_valid;
    // response output register, holds the transaction until taken
    logic signed [pll_pkg::VALUE_W-1:0] r_rsp_data;
    logic [pll_pkg::STAT_W-1:0]         r_rsp_status;

    // second link write (prev.next) is done in S_RESP via a pending register,
    // keeping a single write port
    logic            r_pend;
    logic [AW-1:0]   r_pend_addr;
    logic [LW-1:0]   r_pend_data;
    logic            w_pw;
    assign w_pw = r_pend && (r_state == S_RESP);

    // shared link ram port
    logic            l_we;
    logic [AW-1:0]   l_waddr, l_raddr;
    logic [LW-1:0]   l_wdata, l_rdata;
    logic            v_we;
    logic [AW-1:0]   v_waddr, v_raddr;
    logic [pll_pkg::VALUE_W-1:0] v_rdata;

    pll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );
    pll_ram #(.WIDTH(pll_pkg::VALUE_W), .DEPTH(CAPACITY)) u_value (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(r_value),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    logic w_is_ins, w_is_del;
    assign w_is_ins = r_kind <= pll_pkg::K_INS_POS;
    assign w_is_del = (r_kind >= pll_pkg::K_DEL_FRONT) && (r_kind <= pll_pkg::K_DEL_POS);

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_valid;
    assign o_rsp.data   = r_rsp_data;
    assign o_rsp.status = r_rsp_status;

    // ram port steering; a read address is driven up to the state before
    // the one that uses the registered read data
    always_comb begin
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
        v_we = 1'b0; v_waddr = r_free[AW-1:0]; v_raddr = r_node[AW-1:0];
        case (r_state)
            S_INIT: begin
                l_we = 1'b1; l_waddr = r_init; l_wdata = LW'(r_init) + LW'(1);
            end
            S_WALK_RD: l_raddr = r_node[AW-1:0];
            S_FREE_RD, S_FREE_WAIT: l_raddr = r_free[AW-1:0];
            // insert: node.next = prev.next (or head); store value
            S_LINK: begin
                l_we = 1'b1; l_waddr = r_free[AW-1:0];
                l_wdata = (r_prev == NIL) ? r_head : r_node;
                v_we = 1'b1;
            end
            S_DEL_RD, S_DEL_WAIT: l_raddr = r_node[AW-1:0];
            // delete: victim.next = free head
            S_DEL_FIN: begin
                l_we = 1'b1; l_waddr = r_node[AW-1:0]; l_wdata = r_free;
            end
            // pending prev.next write
            S_RESP: begin
                l_we = w_pw; l_waddr = r_pend_addr; l_wdata = r_pend_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_head  <= NIL;
            r_free  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (r_state == S_RESP && (!r_valid || o_rsp.ready)) r_valid <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_valid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_init <= r_init + AW'(1);
                    if (r_init == AW'(CAPACITY - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_kind  <= i_cmd.kind;
                        r_value <= i_cmd.value;
                        r_target <= TW'(i_cmd.position);
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_data <= '0;
                    r_prev <= NIL;
                    r_node <= r_head;
                    r_step <= TW'(1);
                    if (w_is_ins) begin
                        if (r_count >= NIL) begin
                            r_status <= pll_pkg::ST_FULL; r_state <= S_RESP;
                        end else if (r_kind == pll_pkg::K_INS_FRONT || r_count == '0) begin
                            r_status <= pll_pkg::ST_OK;
                            r_target <= TW'(1); r_state <= S_FREE_RD;
                        end else if (r_kind == pll_pkg::K_INS_BACK) begin
                            r_status <= pll_pkg::ST_OK;
                            r_target <= TW'(r_count) + TW'(1);
                            r_state <= S_WALK_WAIT;
                        end else if (r_target >= TW'(1) &&
                                     r_target <= TW'(r_count) + TW'(1)) begin
                            r_status <= pll_pkg::ST_OK; r_state <= S_WALK_WAIT;
                        end else begin
                            r_status <= pll_pkg::ST_BADPOS; r_state <= S_RESP;
                        end
                    end else if (w_is_del) begin
                        if (r_count == '0) begin
                            r_status <= pll_pkg::ST_UNDER; r_state <= S_RESP;
                        end else if (r_kind == pll_pkg::K_DEL_FRONT || r_count == LW'(1)) begin
                            r_status <= pll_pkg::ST_OK;
                            r_target <= TW'(1); r_state <= S_DEL_RD;
                        end else if (r_kind == pll_pkg::K_DEL_BACK) begin
                            r_status <= pll_pkg::ST_OK;
                            r_target <= TW'(r_count); r_state <= S_WALK_WAIT;
                        end else if (r_target >= TW'(1) &&
                                     r_target <= TW'(r_count)) begin
                            r_status <= pll_pkg::ST_OK; r_state <= S_WALK_WAIT;
                        end else begin
                            r_status <= pll_pkg::ST_BADPOS; r_state <= S_RESP;
                        end
                    end else begin
                        r_status <= pll_pkg::ST_BADPOS; r_state <= S_RESP;
                    end
                end
                // walk until r_prev is node at target-1 and r_node its successor
                S_WALK_WAIT: begin
                    if (r_step >= r_target) begin
                        r_state <= w_is_ins ? S_FREE_RD : S_DEL_RD;
                    end else r_state <= S_WALK_RD;
                end
                S_WALK_RD: r_state <= S_WALK_HOP;
                S_WALK_HOP: begin
                    r_prev <= r_node;
                    r_node <= l_rdata;
                    r_step <= r_step + TW'(1);
                    r_state <= S_WALK_WAIT;
                end
                S_FREE_RD: r_state <= S_FREE_WAIT;
                S_FREE_WAIT: r_state <= S_LINK;
                S_LINK: begin
                    r_free <= l_rdata;
                    if (r_prev == NIL) r_head <= r_free;
                    else begin
                        r_pend <= 1'b1; r_pend_addr <= r_prev[AW-1:0];
                        r_pend_data <= r_free;
                    end
                    r_count <= r_count + LW'(1);
                    r_data  <= r_value;
                    r_state <= S_RESP;
                end
                S_DEL_RD: r_state <= S_DEL_WAIT;
                S_DEL_WAIT: r_state <= S_DEL_FIN;
                S_DEL_FIN: begin
                    if (r_prev == NIL) r_head <= l_rdata;
                    else begin
                        r_pend <= 1'b1; r_pend_addr <= r_prev[AW-1:0];
                        r_pend_data <= l_rdata;
                    end
                    r_free  <= r_node;
                    r_count <= r_count - LW'(1);
                    r_data  <= v_rdata;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // wait for any earlier response to drain, then present
                    if (!r_valid || o_rsp.ready) begin
                        r_pend       <= 1'b0;
                        r_rsp_data   <= r_data;
                        r_rsp_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a waiting response transaction holds still
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=>
            (o_rsp.valid && $stable(o_rsp.data) && $stable(o_rsp.status)));

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready);

    // the list never exceeds the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL);
endmodule

// File: sim/tb_if_dummy.sv
`timescale 1ns / 1ps
// testbench support types for the positional linked list bench
// holds the expected response record; depends on pll_pkg
package tb_pll_pkg;

    typedef struct packed {
        logic signed [pll_pkg::VALUE_W-1:0] data;
        pll_pkg::t_status                   status;
    } t_expected_rsp;

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for positional_linked_list: a shadow list predicts each
// response; directed, full pool and random commands with idle gaps exercise every path
// depends on pll_pkg, pll_if, tb_pll_pkg and the rtl of the block
module tb_top;

    localparam int unsigned CAP        = 32;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_CYC  = 2 * CAP + 20;
    localparam int unsigned VALUE_W    = pll_pkg::VALUE_W;
    localparam int unsigned KIND_W     = pll_pkg::KIND_W;
    localparam int unsigned POS_W      = pll_pkg::POS_W;
    // kind codes with no command behind them
    localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    pll_cmd_if cmd_if (i_clk);
    pll_rsp_if rsp_if (i_clk);

    positional_linked_list #(.CAPACITY(CAP)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // shadow of the list contents, front at index 0
    logic signed [VALUE_W-1:0]  shadow_list[$];
    tb_pll_pkg::t_expected_rsp pending_rsp[$];

    int unsigned fail_count;
    int unsigned rsp_count;
    int unsigned idle_cycles;
    int unsigned status_seen[4];

    // clock, period 10 ns
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // idle length: mostly short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // shadow list update, returns the response that the command should give
    function automatic tb_pll_pkg::t_expected_rsp apply_command(
        logic [KIND_W-1:0] kind,
        logic signed [VALUE_W-1:0] value,
        logic [POS_W-1:0] position
    );
        tb_pll_pkg::t_expected_rsp rsp;
        int            cnt;
        int            idx;
        cnt        = shadow_list.size();
        rsp.data   = '0;
        rsp.status = pll_pkg::ST_OK;
        idx        = -1;
        case (kind)
            pll_pkg::K_INS_FRONT, pll_pkg::K_INS_BACK, pll_pkg::K_INS_POS: begin
                if (cnt >= CAP) begin
                    rsp.status = pll_pkg::ST_FULL;
                end else if (kind == pll_pkg::K_INS_FRONT || cnt == 0) begin
                    idx = 0;
                end else if (kind == pll_pkg::K_INS_BACK) begin
                    idx = cnt;
                end else if (position >= 1 && position <= cnt + 1) begin
                    idx = position - 1;
                end else begin
                    rsp.status = pll_pkg::ST_BADPOS;
                end
                if (idx >= 0) begin
                    shadow_list.insert(idx, value);
                    rsp.data = value;
                end
            end
            pll_pkg::K_DEL_FRONT, pll_pkg::K_DEL_BACK, pll_pkg::K_DEL_POS: begin
                if (cnt == 0) begin
                    rsp.status = pll_pkg::ST_UNDER;
                end else if (kind == pll_pkg::K_DEL_FRONT || cnt == 1) begin
                    idx = 0;
                end else if (kind == pll_pkg::K_DEL_BACK) begin
                    idx = cnt - 1;
                end else if (position >= 1 && position <= cnt) begin
                    idx = position - 1;
                end else begin
                    rsp.status = pll_pkg::ST_BADPOS;
                end
                if (idx >= 0) begin
                    rsp.data = shadow_list[idx];
                    shadow_list.delete(idx);
                end
            end
            default: begin
                rsp.status = pll_pkg::ST_BADPOS;
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // send one command transaction after a random gap; prediction happens at acceptance
    // valid stays high after acceptance so a zero gap gives back to back commands
    task automatic send_command(
        input logic [KIND_W-1:0] kind,
        input logic signed [VALUE_W-1:0] value,
        input logic [POS_W-1:0] position
    );
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.kind     <= kind;
        cmd_if.value    <= value;
        cmd_if.position <= position;
        do begin
            @(posedge i_clk);
        end while (!cmd_if.ready);
        pending_rsp.push_back(apply_command(kind, value, position));
    endtask

    // stop sending and hold off until every expected response is back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_rsp.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(0, 7);
        case (r)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '1;
            3: return '0;
            default: return $signed($urandom);
        endcase
    endfunction

    // position: mostly legal for the current list, sometimes out of range
    function automatic logic [POS_W-1:0] rand_position(input int extra);
        int unsigned r;
        int          top;
        r   = $urandom_range(0, 9);
        top = shadow_list.size() + extra;
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return POS_W'($urandom_range(0, 255));
        end else if (r == 2) begin
            return POS_W'(top + 1);
        end
        if (top < 1) begin
            top = 1;
        end
        return POS_W'($urandom_range(1, top));
    endfunction

    // every kind and edge of the fields on a small list
    task automatic test_directed();
        send_command(pll_pkg::K_DEL_FRONT, '0, '0);
        send_command(pll_pkg::K_DEL_POS, '0, 8'd5);
        send_command(pll_pkg::K_INS_POS, 32'sh7fff_ffff, 8'd200);
        send_command(pll_pkg::K_DEL_POS, '0, 8'd255);
        send_command(pll_pkg::K_INS_FRONT, 32'sh8000_0000, '0);
        send_command(pll_pkg::K_INS_BACK, -32'sd1, '0);
        send_command(pll_pkg::K_INS_POS, 32'sh5a5a_a5a5, 8'd2);
        send_command(pll_pkg::K_INS_POS, 32'sd11, 8'd4);
        send_command(pll_pkg::K_INS_POS, 32'sd12, 8'd6);
        send_command(pll_pkg::K_INS_POS, 32'sd13, '0);
        send_command(pll_pkg::K_DEL_POS, '0, '0);
        send_command(pll_pkg::K_DEL_POS, '0, 8'd5);
        send_command(pll_pkg::K_DEL_POS, '0, 8'd4);
        send_command(pll_pkg::K_DEL_POS, '0, 8'd2);
        send_command(pll_pkg::K_DEL_BACK, '0, '0);
        send_command(K_SPARE_LO, 32'sh1234_5678, 8'hff);
        send_command(K_SPARE_HI, '0, 8'd1);
        send_command(pll_pkg::K_DEL_FRONT, '0, '0);
        send_command(pll_pkg::K_DEL_BACK, '0, '0);
    endtask

    // fill the pool to capacity, overflow it, then empty it from the back
    task automatic test_full_pool();
        while (shadow_list.size() < CAP) begin
            send_command(pll_pkg::K_INS_BACK, rand_value(), '0);
        end
        send_command(pll_pkg::K_INS_FRONT, 32'sd1, '0);
        send_command(pll_pkg::K_INS_BACK, 32'sd2, '0);
        send_command(pll_pkg::K_INS_POS, 32'sd3, 8'd1);
        send_command(pll_pkg::K_DEL_POS, '0, POS_W'(CAP));
        send_command(pll_pkg::K_INS_POS, 32'sd4, POS_W'(CAP));
        send_command(pll_pkg::K_DEL_POS, '0, 8'd1);
        // hold off until all responses are back
        wait_drained();
        while (shadow_list.size() > 0) begin
            send_command(pll_pkg::K_DEL_BACK, '0, '0);
        end
        send_command(pll_pkg::K_DEL_BACK, '0, '0);
    endtask

    // random mix; the insert bias drifts so the list swings between empty and full
    task automatic test_random(input int unsigned n);
        int unsigned ins_bias;
        int unsigned r;
        logic [KIND_W-1:0] kind;
        ins_bias = 50;
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                ins_bias = $urandom_range(20, 80);
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                kind = ($urandom_range(0, 1) == 0) ? K_SPARE_LO : K_SPARE_HI;
            end else if ($urandom_range(0, 99) < ins_bias) begin
                kind = KIND_W'($urandom_range(pll_pkg::K_INS_FRONT, pll_pkg::K_INS_POS));
            end else begin
                kind = KIND_W'($urandom_range(pll_pkg::K_DEL_FRONT, pll_pkg::K_DEL_POS));
            end
            send_command(kind, rand_value(),
                         rand_position(kind <= pll_pkg::K_INS_POS ? 1 : 0));
        end
    endtask

    // response checker, with random back-pressure
    initial begin
        tb_pll_pkg::t_expected_rsp exp_rsp;
        int unsigned   gap;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_count++;
                if (pending_rsp.size() == 0) begin
                    report_mismatch("response with nothing expected");
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    status_seen[exp_rsp.status]++;
                    if (rsp_if.status !== exp_rsp.status) begin
                        report_mismatch($sformatf("status %0d expected %0d",
                                        rsp_if.status, exp_rsp.status));
                    end
                    if (rsp_if.data !== exp_rsp.data) begin
                        report_mismatch($sformatf("data %0d expected %0d",
                                        rsp_if.data, exp_rsp.data));
                    end
                end
                gap = gap_len();
                if (gap != 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    rsp_if.ready <= 1'b1;
                end
            end else if (!rsp_if.ready) begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired, %0d responses pending", pending_rsp.size());
                $display("[positional_linked_list] ERROR");
                $finish;
            end
        end
    end

    initial begin
        fail_count      = 0;
        rsp_count       = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.kind     = '0;
        cmd_if.value    = '0;
        cmd_if.position = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_pool();
        test_random(1500);
        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("run covered %0d responses from directed, full pool and random commands",
                 rsp_count);
        $display("statuses: ok %0d, underflow %0d, full %0d, bad position %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0) begin
            $display("[positional_linked_list] OK");
        end else begin
            $display("[positional_linked_list] ERROR");
        end
        $finish;
    end

endmodule
